/* rtl/iabd_pkg.sv */
package iabd_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned INDEX_BITS  = 7;
  localparam int unsigned STEP_BITS   = 15;

  localparam logic signed [17:0] PRED_MIN = -18'sd32768;
  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [8:0]  INDEX_MAX = 9'sd88;
  localparam logic [3:0]         NIBBLE_MASK = 4'hF;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [INDEX_BITS-1:0]         index_t;
  typedef logic [STEP_BITS-1:0]          step_t;

  // decoder output for one nibble
  typedef struct packed {
    sample_t sample;
    index_t  index;
  } nib_result_t;

  function automatic logic signed [4:0] index_adjust(input logic [3:0] code);
    logic signed [4:0] adj;
    unique case (code[2:0])
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

  function automatic step_t step_size(input index_t idx);
    step_t s;
    unique case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
      7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
      7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // one ima-adpcm nibble: predictor update with 16-bit clamp, index update with 0..88 clamp
  function automatic nib_result_t decode_nibble(input sample_t pred, input index_t idx,
                                                input logic [3:0] code_in);
    logic [3:0]         code;
    step_t              step;
    logic [16:0]        diff;
    logic signed [17:0] sum;
    logic signed [8:0]  nidx;
    nib_result_t        r;
    code = code_in & NIBBLE_MASK;
    step = step_size(idx);
    diff = {5'd0, step[14:3]};
    if (code[2]) diff = diff + {2'd0, step};
    if (code[1]) diff = diff + {3'd0, step[14:1]};
    if (code[0]) diff = diff + {4'd0, step[14:2]};
    if (code[3]) sum = 18'(pred) - $signed({1'b0, diff});
    else         sum = 18'(pred) + $signed({1'b0, diff});
    if (sum < PRED_MIN)      r.sample = PRED_MIN[15:0];
    else if (sum > PRED_MAX) r.sample = PRED_MAX[15:0];
    else                     r.sample = sum[15:0];
    nidx = $signed({2'b00, idx}) + 9'(index_adjust(code));
    if (nidx < 9'sd0)          r.index = '0;
    else if (nidx > INDEX_MAX) r.index = INDEX_MAX[6:0];
    else                       r.index = nidx[6:0];
    return r;
  endfunction

endpackage

/* rtl/ima_adpcm_byte_decoder.sv */
// Mono 4-bit IMA-ADPCM decoder taking one packed byte per beat, low nibble first, and giving
// one 16-bit sample per output beat. A byte is held in an input register and its two nibbles go
// through a single nibble decoder one after the other; while the output is not stalled, the output
// runs at one sample per cycle. The high nibble of a byte whose low nibble is the last sample of
// the track is dropped. The first sample of a byte is decoded from the input register into the
// output sample register, and the next byte is taken while results are
// still waiting. out_tlast marks the final sample of a byte, out_tuser the last sample of the
// track; after that sample the predictor and step index return to zero and the sample counter
// reloads, so the track loops. A write on the cfg port sets the track length (low COUNT_BITS
// bits, zero meaning 2^COUNT_BITS) and rewinds at once; write only while the block is idle.
module ima_adpcm_byte_decoder #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,   // sample_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] packed_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] sample
  output logic        out_tlast,   // last_of_byte
  output logic        out_tuser    // [0] track_end
);
  import iabd_pkg::*;

  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] left_r, left_nxt;
  sample_t               pred_r, pred_nxt;
  index_t                idx_r, idx_nxt;
  logic [7:0]            byte_r;
  logic                  byte_valid_r, byte_valid_nxt;
  logic                  phase_r, phase_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sample_t               out_sample_r;
  logic                  out_last_r, out_end_r;

  logic        advance, track_end, byte_done, in_fire;
  logic [3:0]  code;
  nib_result_t nib;

  assign advance   = byte_valid_r && (!out_valid_r || out_tready);
  assign code      = phase_r ? byte_r[7:4] : byte_r[3:0];
  assign nib       = decode_nibble(pred_r, idx_r, code);
  assign track_end = (left_r == COUNT_BITS'(1));
  assign byte_done = phase_r || track_end;
  assign in_tready = !byte_valid_r || (advance && byte_done);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    pred_nxt       = pred_r;
    idx_nxt        = idx_r;
    left_nxt       = left_r;
    phase_nxt      = phase_r;
    byte_valid_nxt = byte_valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (advance) begin
      out_valid_nxt = 1'b1;
      // rewind right after the last sample of the track
      if (track_end) begin
        pred_nxt = '0;
        idx_nxt  = '0;
        left_nxt = count_r;
      end else begin
        pred_nxt = nib.sample;
        idx_nxt  = nib.index;
        left_nxt = left_r - COUNT_BITS'(1);
      end
      if (byte_done) begin
        phase_nxt      = 1'b0;
        byte_valid_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
      end
    end
    if (in_fire) begin
      byte_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= COUNT_BITS'(1);
      left_r       <= COUNT_BITS'(1);
      pred_r       <= '0;
      idx_r        <= '0;
      byte_valid_r <= 1'b0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata[COUNT_BITS-1:0];
        left_r  <= cfg_wdata[COUNT_BITS-1:0];
        pred_r  <= '0;
        idx_r   <= '0;
      end else begin
        left_r <= left_nxt;
        pred_r <= pred_nxt;
        idx_r  <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_tdata;
    end
    if (advance) begin
      out_sample_r <= nib.sample;
      out_last_r   <= byte_done;
      out_end_r    <= track_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

endmodule
